@@ hdl/ffha_pkg.sv @@
package ffha_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int POOL_PAGES   = 256;
  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 24;
  localparam int ALIGN_BYTES  = 16;
  localparam int MIN_SPLIT    = 32;
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NULL    = 3'd1;
  localparam logic [2:0] ST_PAGES   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NOMATCH = 3'd4;

  typedef struct packed {
    logic [19:0] off;
    logic [20:0] size;
    logic        free;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t ent;
  } link_t;

  function automatic logic [22:0] round16(input logic [22:0] v);
    logic [22:0] s;
    s = v + 23'(ALIGN_BYTES - 1);
    return s & ~23'(ALIGN_BYTES - 1);
  endfunction

endpackage

@@ hdl/ffha_cell.sv @@
module ffha_cell import ffha_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  link_t up,
  input  logic  down_free,
  output link_t cur
);

  logic   full;
  entry_t ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (full && down_free) begin
      full <= 1'b0;
    end else if (!full && up.valid) begin
      full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!full && up.valid) begin
      ent <= up.ent;
    end
  end

  assign cur.valid = full;
  assign cur.ent   = ent;

endmodule

@@ hdl/ffha_ctrl.sv @@
module ffha_ctrl import ffha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        operation,
  input  logic [20:0] request_size,
  input  logic [19:0] free_address,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [19:0] address,
  output logic [2:0]  status,
  output logic [20:0] pool_bytes,
  output logic [20:0] live_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  input  link_t       head,
  input  logic        tail_full,
  output logic        pop,
  output link_t       push
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_PASS      = 7'b0000010,
    S_DECIDE    = 7'b0000100,
    S_GROW_NEW  = 7'b0001000,
    S_GROW_TAKE = 7'b0010000,
    S_FREE_END  = 7'b0100000,
    S_RESP      = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    M_SCAN = 2'd0,
    M_TAKE = 2'd1,
    M_GROW = 2'd2,
    M_FREE = 2'd3
  } mode_t;

  state_t            state;
  mode_t             mode;
  logic [21:0]       sz;
  logic [19:0]       fa;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  pop_left;
  logic [8:0]        nfp;
  logic [20:0]       region;
  logic [20:0]       alloc;
  logic [8:0]        page_limit;
  logic              found;
  logic              hit_free;
  logic [19:0]       res_addr;
  logic [2:0]        res_status;
  entry_t            acc;
  logic              acc_v;
  entry_t            nb;
  entry_t            q0;
  entry_t            q1;
  logic [1:0]        qn;

  entry_t      sx;
  entry_t      mx;
  entry_t      p0;
  entry_t      p1;
  logic [1:0]  pn;
  logic        addr_hit;
  logic        mark;
  logic [22:0] acc_end;
  logic        joinable;
  logic        fit;
  logic        cut;
  logic        cut_acc;
  logic        step;
  logic [22:0] grow_bytes;
  logic [23:0] pg_sum;
  logic [11:0] pages;
  logic [8:0]  lim;
  logic [8:0]  room;
  logic        no_pages;
  logic        load;
  logic [22:0] sz_round;

  always_comb begin
    sx       = (state == S_PASS) ? head.ent : nb;
    addr_hit = ({1'b0, sx.off} + 21'(HEADER_BYTES)) == {1'b0, fa};
    mark     = (mode == M_FREE) && !found && addr_hit;
    mx       = sx;
    if (mark) begin
      mx.free = 1'b1;
    end
    acc_end  = {3'b0, acc.off} + 23'(HEADER_BYTES) + round16({2'b0, acc.size});
    joinable = acc_v && acc.free && mx.free && (acc_end == {3'b0, mx.off});
    fit      = !found && sx.free && ({1'b0, sx.size} >= sz);
    cut      = fit && ({1'b0, sx.size} >= sz + 22'(HEADER_BYTES + MIN_SPLIT))
               && (count < CNT_W'(MAX_BLOCKS));
    cut_acc  = ({1'b0, acc.size} >= sz + 22'(HEADER_BYTES + MIN_SPLIT))
               && (count < CNT_W'(MAX_BLOCKS));
    p0 = sx;
    p1 = sx;
    pn = 2'd0;
    case (mode)
      M_SCAN: begin
        pn = 2'd1;
      end
      M_TAKE: begin
        pn = 2'd1;
        if (cut) begin
          p0.size = sz[20:0];
          p0.free = 1'b0;
          p1.off  = sx.off + 20'(HEADER_BYTES) + sz[19:0];
          p1.size = sx.size - sz[20:0] - 21'(HEADER_BYTES);
          p1.free = 1'b1;
          pn      = 2'd2;
        end else if (fit) begin
          p0.free = 1'b0;
        end
      end
      default: begin
        if (acc_v && !joinable) begin
          p0 = acc;
          pn = 2'd1;
        end
      end
    endcase
  end

  always_comb begin
    grow_bytes = round16({1'b0, sz} + 23'(HEADER_BYTES));
    pg_sum     = {1'b0, grow_bytes} + 24'(PAGE_BYTES - 1);
    pages      = pg_sum[23:PAGE_SHIFT];
    lim        = (page_limit < 9'(POOL_PAGES)) ? page_limit : 9'(POOL_PAGES);
    room       = lim - nfp;
    no_pages   = (nfp >= lim) || (pages > {3'b0, room});
  end

  assign sz_round  = round16({2'b0, request_size});
  assign step      = (state == S_PASS) && (pop_left != '0) && (qn == 2'd0) && head.valid;
  assign pop       = step;
  assign push      = '{valid: (qn != 2'd0), ent: q0};
  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign load      = (state == S_RESP) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= M_SCAN;
      count      <= '0;
      pop_left   <= '0;
      nfp        <= '0;
      region     <= '0;
      alloc      <= '0;
      page_limit <= 9'(POOL_PAGES);
      found      <= 1'b0;
      acc_v      <= 1'b0;
      qn         <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        page_limit <= cfg_data;
      end
      if (qn != 2'd0 && !tail_full) begin
        q0 <= q1;
        qn <= qn - 2'd1;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            res_addr <= '0;
            found    <= 1'b0;
            acc_v    <= 1'b0;
            pop_left <= count;
            sz       <= sz_round[21:0];
            fa       <= free_address;
            if (operation == OP_ALLOC) begin
              mode <= M_TAKE;
              if (request_size == '0) begin
                res_status <= ST_NULL;
                state      <= S_RESP;
              end else begin
                state <= S_PASS;
              end
            end else begin
              mode <= M_SCAN;
              if (free_address == '0) begin
                res_status <= ST_NULL;
                state      <= S_RESP;
              end else begin
                state <= S_PASS;
              end
            end
          end
        end
        S_PASS: begin
          if (step) begin
            pop_left <= pop_left - CNT_W'(1);
            q0       <= p0;
            q1       <= p1;
            qn       <= pn;
            case (mode)
              M_SCAN: begin
                if (!found && addr_hit) begin
                  found    <= 1'b1;
                  hit_free <= sx.free;
                end
              end
              M_TAKE: begin
                if (fit) begin
                  found    <= 1'b1;
                  res_addr <= sx.off + 20'(HEADER_BYTES);
                  alloc    <= alloc + (cut ? sz[20:0] : sx.size);
                  if (cut) begin
                    count <= count + CNT_W'(1);
                  end
                end
              end
              default: begin
                if (mark) begin
                  found <= 1'b1;
                  alloc <= alloc - sx.size;
                end
                if (joinable) begin
                  acc.size <= acc.size + 21'(HEADER_BYTES) + mx.size;
                  count    <= count - CNT_W'(1);
                end else begin
                  acc   <= mx;
                  acc_v <= 1'b1;
                end
              end
            endcase
          end else if (pop_left == '0 && qn == 2'd0) begin
            case (mode)
              M_GROW:  state <= S_GROW_NEW;
              M_FREE:  state <= S_FREE_END;
              default: state <= S_DECIDE;
            endcase
          end
        end
        S_DECIDE: begin
          if (mode == M_SCAN) begin
            if (!found || hit_free) begin
              res_status <= ST_NOMATCH;
              state      <= S_RESP;
            end else begin
              mode     <= M_FREE;
              found    <= 1'b0;
              acc_v    <= 1'b0;
              pop_left <= count;
              state    <= S_PASS;
            end
          end else if (found) begin
            res_status <= ST_OK;
            state      <= S_RESP;
          end else if (no_pages) begin
            res_status <= ST_PAGES;
            state      <= S_RESP;
          end else if (count >= CNT_W'(MAX_BLOCKS)) begin
            res_status <= ST_FULL;
            state      <= S_RESP;
          end else begin
            nb.off   <= 20'(nfp) << PAGE_SHIFT;
            nb.size  <= (21'(pages) << PAGE_SHIFT) - 21'(HEADER_BYTES);
            nb.free  <= 1'b1;
            nfp      <= nfp + pages[8:0];
            region   <= region + (21'(pages) << PAGE_SHIFT) - 21'(HEADER_BYTES);
            count    <= count + CNT_W'(1);
            pop_left <= count;
            acc_v    <= 1'b0;
            mode     <= M_GROW;
            state    <= S_PASS;
          end
        end
        S_GROW_NEW: begin
          q0 <= p0;
          qn <= pn;
          if (joinable) begin
            acc.size <= acc.size + 21'(HEADER_BYTES) + mx.size;
            count    <= count - CNT_W'(1);
          end else begin
            acc   <= mx;
            acc_v <= 1'b1;
          end
          state <= S_GROW_TAKE;
        end
        S_GROW_TAKE: begin
          if (qn == 2'd0) begin
            q0.off   <= acc.off;
            q0.free  <= 1'b0;
            res_addr <= acc.off + 20'(HEADER_BYTES);
            if (cut_acc) begin
              q0.size <= sz[20:0];
              q1.off  <= acc.off + 20'(HEADER_BYTES) + sz[19:0];
              q1.size <= acc.size - sz[20:0] - 21'(HEADER_BYTES);
              q1.free <= 1'b1;
              qn      <= 2'd2;
              count   <= count + CNT_W'(1);
              alloc   <= alloc + sz[20:0];
            end else begin
              q0.size <= acc.size;
              qn      <= 2'd1;
              alloc   <= alloc + acc.size;
            end
            acc_v      <= 1'b0;
            res_status <= ST_OK;
            state      <= S_RESP;
          end
        end
        S_FREE_END: begin
          if (acc_v) begin
            q0 <= acc;
            qn <= 2'd1;
          end
          acc_v      <= 1'b0;
          res_status <= ST_OK;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      address    <= res_addr;
      status     <= res_status;
      pool_bytes <= region;
      live_bytes <= alloc;
    end
  end

`ifndef NO_ASSERTIONS
  a_queue_depth: assert property (@(posedge clk) disable iff (rst) qn <= 2'd2)
    else $error("word queue overflow");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("pop of empty head cell");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BLOCKS))
    else $error("block count above table depth");
  a_grow_acc: assert property (@(posedge clk) disable iff (rst)
    state == S_GROW_TAKE |-> acc_v)
    else $error("no last block to hand out after growth");
`endif

endmodule

@@ hdl/first_fit_heap_allocator_top.sv @@
// channel  | direction | handshake            | word
// req      | in        | req_valid/req_stall  | operation, request_size, free_address
// rsp      | out       | rsp_valid/rsp_stall  | address, status, pool_bytes, live_bytes
// cfg      | in        | cfg_valid/cfg_ready  | cfg_data (page_limit)
//
// one request at a time; a zero-size allocate or a null free goes straight to its response
// others pass the block chain once (allocate that fits or fails, free of no used block)
// or twice (other free, allocate that grows); a pass pops each block from the head cell
// and pushes it back at the tail, waiting while the tail is full or a push is in flight
// reset is synchronous; the block chain comes up empty and page_limit is 256
// a held response does not block taking the next request, only loading its response
module first_fit_heap_allocator_top import ffha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        operation,
  input  logic [20:0] request_size,
  input  logic [19:0] free_address,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [19:0] address,
  output logic [2:0]  status,
  output logic [20:0] pool_bytes,
  output logic [20:0] live_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);

  link_t lnk [MAX_BLOCKS];
  link_t push;
  logic  pop;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    link_t up;
    logic  down_free;
    if (k == MAX_BLOCKS - 1) begin : g_tail
      assign up = push;
    end else begin : g_mid
      assign up = lnk[k+1];
    end
    if (k == 0) begin : g_head
      assign down_free = pop;
    end else begin : g_rest
      assign down_free = !lnk[k-1].valid;
    end
    ffha_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .up        (up),
      .down_free (down_free),
      .cur       (lnk[k])
    );
  end

  ffha_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .operation    (operation),
    .request_size (request_size),
    .free_address (free_address),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .address      (address),
    .status       (status),
    .pool_bytes   (pool_bytes),
    .live_bytes   (live_bytes),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .head         (lnk[0]),
    .tail_full    (lnk[MAX_BLOCKS-1].valid),
    .pop          (pop),
    .push         (push)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import ffha_pkg::*;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int SETTLE_CYCLES  = 300;

  typedef struct {
    logic [19:0] address;
    logic [2:0]  status;
    logic [20:0] pool_bytes;
    logic [20:0] live_bytes;
  } alloc_result_t;

  class heap_scoreboard;
    longint unsigned blk_off[MAX_BLOCKS];
    longint unsigned blk_size[MAX_BLOCKS];
    bit              blk_free[MAX_BLOCKS];
    int              nblocks;
    longint unsigned page_next;
    longint unsigned region_total;
    longint unsigned used_total;
    longint unsigned pages_allowed;
    alloc_result_t   expected_q[$];
    logic [19:0]     live_addrs[$];
    logic [19:0]     freed_addrs[$];
    int              mismatches;
    int              checked;
    int              status_hits[5];

    function new();
      nblocks = 0;
      page_next = 0;
      region_total = 0;
      used_total = 0;
      pages_allowed = 256;
      mismatches = 0;
      checked = 0;
    endfunction

    function longint unsigned align16(longint unsigned v);
      return (v + 15) & ~64'd15;
    endfunction

    function void drop_entry(int i);
      for (int k = i; k + 1 < nblocks; k++) begin
        blk_off[k] = blk_off[k + 1];
        blk_size[k] = blk_size[k + 1];
        blk_free[k] = blk_free[k + 1];
      end
      nblocks--;
    endfunction

    function void coalesce();
      int i;
      longint unsigned tail;
      i = 0;
      while (i + 1 < nblocks) begin
        tail = blk_off[i] + HEADER_BYTES + align16(blk_size[i]);
        if (blk_free[i] && blk_free[i + 1] && tail == blk_off[i + 1]) begin
          blk_size[i] += HEADER_BYTES + blk_size[i + 1];
          drop_entry(i + 1);
        end else begin
          i++;
        end
      end
    endfunction

    function longint unsigned claim(int i, longint unsigned sz);
      if (blk_size[i] >= sz + HEADER_BYTES + MIN_SPLIT && nblocks < MAX_BLOCKS) begin
        for (int k = nblocks; k > i + 1; k--) begin
          blk_off[k] = blk_off[k - 1];
          blk_size[k] = blk_size[k - 1];
          blk_free[k] = blk_free[k - 1];
        end
        blk_off[i + 1] = blk_off[i] + HEADER_BYTES + sz;
        blk_size[i + 1] = blk_size[i] - sz - HEADER_BYTES;
        blk_free[i + 1] = 1;
        blk_size[i] = sz;
        nblocks++;
      end
      blk_free[i] = 0;
      used_total += blk_size[i];
      return blk_off[i] + HEADER_BYTES;
    endfunction

    function logic [2:0] allocate(longint unsigned req, output longint unsigned addr);
      longint unsigned sz, bytes, pages, lim;
      addr = 0;
      if (req == 0) return ST_NULL;
      sz = align16(req);
      for (int i = 0; i < nblocks; i++) begin
        if (blk_free[i] && blk_size[i] >= sz) begin
          addr = claim(i, sz);
          return ST_OK;
        end
      end
      bytes = align16(sz + HEADER_BYTES);
      pages = (bytes + PAGE_BYTES - 1) / PAGE_BYTES;
      lim = pages_allowed < POOL_PAGES ? pages_allowed : POOL_PAGES;
      if (page_next >= lim || pages > lim - page_next) return ST_PAGES;
      if (nblocks >= MAX_BLOCKS) return ST_FULL;
      blk_off[nblocks] = page_next * PAGE_BYTES;
      blk_size[nblocks] = pages * PAGE_BYTES - HEADER_BYTES;
      blk_free[nblocks] = 1;
      nblocks++;
      page_next += pages;
      region_total += pages * PAGE_BYTES - HEADER_BYTES;
      coalesce();
      addr = claim(nblocks - 1, sz);
      return ST_OK;
    endfunction

    function logic [2:0] release_addr(longint unsigned a);
      if (a == 0) return ST_NULL;
      for (int i = 0; i < nblocks; i++) begin
        if (blk_off[i] + HEADER_BYTES == a) begin
          if (blk_free[i]) return ST_NOMATCH;
          blk_free[i] = 1;
          used_total -= blk_size[i];
          coalesce();
          return ST_OK;
        end
      end
      return ST_NOMATCH;
    endfunction

    function void set_limit(logic [8:0] v);
      pages_allowed = v;
    endfunction

    function void note_request(logic op, logic [20:0] sz, logic [19:0] fa);
      alloc_result_t   r;
      longint unsigned addr;
      addr = 0;
      if (op == OP_ALLOC) begin
        r.status = allocate(sz, addr);
        if (r.status == ST_OK) live_addrs.push_back(addr[19:0]);
      end else begin
        r.status = release_addr(fa);
        if (r.status == ST_OK) begin
          foreach (live_addrs[i]) begin
            if (live_addrs[i] == fa) begin
              live_addrs.delete(i);
              break;
            end
          end
          freed_addrs.push_back(fa);
          if (freed_addrs.size() > 16) void'(freed_addrs.pop_front());
        end
      end
      r.address = addr[19:0];
      r.pool_bytes = region_total[20:0];
      r.live_bytes = used_total[20:0];
      status_hits[r.status]++;
      expected_q.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: addr %0d status %0d",
                                       got.address, got.status);
        return;
      end
      want = expected_q.pop_front();
      if (got.address !== want.address || got.status !== want.status ||
          got.pool_bytes !== want.pool_bytes || got.live_bytes !== want.live_bytes) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp addr %0d st %0d pool %0d live %0d,",
                    " got addr %0d st %0d pool %0d live %0d"},
                   want.address, want.status, want.pool_bytes, want.live_bytes,
                   got.address, got.status, got.pool_bytes, got.live_bytes);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic        operation;
  logic [20:0] request_size;
  logic [19:0] free_address;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [19:0] address;
  logic [2:0]  status;
  logic [20:0] pool_bytes;
  logic [20:0] live_bytes;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [8:0]  cfg_data;

  heap_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_rsp;
  int  quiet_cycles;
  int  items_sent;

  first_fit_heap_allocator_top u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .request_size(request_size), .free_address(free_address),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .address(address), .status(status), .pool_bytes(pool_bytes), .live_bytes(live_bytes),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    rsp_stall <= hold_rsp || ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    alloc_result_t got;
    if (!rst && req_valid && !req_stall) sb.note_request(operation, request_size, free_address);
    if (!rst && rsp_valid && !rsp_stall) begin
      got.address = address;
      got.status = status;
      got.pool_bytes = pool_bytes;
      got.live_bytes = live_bytes;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d words outstanding", sb.expected_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_word(logic op, logic [20:0] sz, logic [19:0] fa);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    operation <= op;
    request_size <= sz;
    free_address <= fa;
    do @(posedge clk); while (req_stall);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [8:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_limit(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random();
    int r;
    logic [20:0] sz;
    logic [19:0] fa;
    sz = 21'($urandom);
    fa = 20'($urandom);
    if ($urandom_range(0, 99) < 55) begin
      r = $urandom_range(0, 199);
      if (r < 4) sz = 0;
      else if (r < 160) sz = 21'($urandom_range(1, 512));
      else if (r < 190) sz = 21'($urandom_range(513, 8192));
      else if (r < 199) sz = 21'($urandom_range(8193, 65536));
      else sz = 21'($urandom_range(0, 1048576));
      send_word(OP_ALLOC, sz, fa);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65 && sb.live_addrs.size() != 0)
        fa = sb.live_addrs[$urandom_range(0, sb.live_addrs.size() - 1)];
      else if (r < 75 && sb.freed_addrs.size() != 0)
        fa = sb.freed_addrs[$urandom_range(0, sb.freed_addrs.size() - 1)];
      else if (r < 80) fa = 0;
      else if (r < 90) fa = 20'(($urandom_range(0, 65535) << 4) + 8);
      send_word(OP_FREE, sz, fa);
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    req_valid = 0;
    operation = 0;
    request_size = 0;
    free_address = 0;
    rsp_stall = 0;
    cfg_valid = 0;
    cfg_data = 0;
    hold_rsp = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    write_limit(9'd256);
    send_word(OP_ALLOC, 21'd0, 20'hFFFFF);
    send_word(OP_FREE, 21'h1FFFFF, 20'd0);
    send_word(OP_FREE, 21'd0, 20'd24);
    send_word(OP_ALLOC, 21'd1, 20'd0);
    send_word(OP_ALLOC, 21'd16, 20'd0);
    send_word(OP_ALLOC, 21'd17, 20'd0);
    send_word(OP_FREE, 21'd0, 20'd24);
    send_word(OP_FREE, 21'd0, 20'd24);
    send_word(OP_FREE, 21'd0, 20'd40);
    send_word(OP_ALLOC, 21'd4040, 20'd0);
    send_word(OP_ALLOC, 21'd4072, 20'd0);
    send_word(OP_ALLOC, 21'd1048576, 20'd0);
    send_word(OP_ALLOC, 21'd8000, 20'd0);
    send_word(OP_FREE, 21'd0, 20'hFFFFF);
    send_word(OP_FREE, 21'd0, 20'd72);
    send_word(OP_ALLOC, 21'd3000, 20'd0);
    for (int i = 0; i < 8; i++) send_word(OP_FREE, 21'd0, sb.live_addrs.size() ?
                                          sb.live_addrs[0] : 20'd8);
    drain();

    send_idle_pct = 11;
    recv_idle_pct = 59;
    repeat (400) send_random();
    drain();

    write_limit(9'd1);
    send_idle_pct = 59;
    recv_idle_pct = 11;
    repeat (150) send_random();
    drain();

    write_limit(9'd511);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_rsp = 1;
        repeat (600) @(posedge clk);
        hold_rsp = 0;
      end
    join_none
    for (int i = 0; i < 150; i++) begin
      send_random();
      if (sb.live_addrs.size() > 40) send_word(OP_FREE, 21'd0, sb.live_addrs[0]);
    end
    drain();

    write_limit(9'd200);
    repeat (300) send_random();
    drain();

    write_limit(9'd256);
    send_idle_pct = 11;
    recv_idle_pct = 59;
    repeat (280) send_random();
    drain();

    $display("%0d requests, %0d words checked; ok %0d, null %0d, no pages %0d",
             items_sent, sb.checked, sb.status_hits[ST_OK], sb.status_hits[ST_NULL],
             sb.status_hits[ST_PAGES]);
    $display("full %0d, no match %0d; page limits 1, 200, 256, 511, long hold; %0d mismatches",
             sb.status_hits[ST_FULL], sb.status_hits[ST_NOMATCH], sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
